### design/dsf_pkg.sv
// Shared types, constants and register codes of the damped 2D spring force core.
package dsf_pkg;

  // Register indexes of the configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_RATIO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_MIN   = 2'd3;

  // Register reset values (Q16.16)
  localparam logic [31:0] STIFFNESS_RST   = 32'd3276800;
  localparam logic [31:0] DAMPING_RST     = 32'd6554;
  localparam logic [31:0] BREAK_RATIO_RST = 32'd9830;
  localparam logic [31:0] BREAK_MIN_RST   = 32'd655360;

  // Pipeline depths
  localparam int unsigned SQ_STEPS  = 32;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_LANES = 3;
  localparam int unsigned LATENCY   = 3 + SQ_STEPS + 3 + DIV_STEPS + 4;

  // Divider lanes
  localparam int unsigned LANE_DOT = 0;
  localparam int unsigned LANE_UX  = 1;
  localparam int unsigned LANE_UY  = 2;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic        [30:0] rest_length;
  } in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               broken;
  } out_t;

  // Item data that rides along the square root pipeline
  typedef struct packed {
    logic        dx_neg;
    logic        dy_neg;
    logic [31:0] dx_mag;
    logic [31:0] dy_mag;
    logic        dot_neg;
    logic [63:0] dot_mag;
    logic [30:0] rest;
  } sq_side_t;

  // Item data that rides along the divider pipeline
  typedef struct packed {
    logic        brk;
    logic        nzero;
    logic        s_neg;
    logic [47:0] hm;
    logic        dot_neg;
    logic        ovf;
    logic        dx_neg;
    logic        dy_neg;
  } dv_side_t;

  typedef logic [DIV_LANES-1:0][31:0] lane_t;

endpackage

### design/dsf_isqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
module dsf_isqrt import dsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] in_rad,
  input  sq_side_t    in_side,
  output logic        out_valid,
  output logic [31:0] out_root,
  output sq_side_t    out_side
);

  logic        vld  [SQ_STEPS];
  logic [34:0] rem  [SQ_STEPS];
  logic [31:0] root [SQ_STEPS];
  logic [63:0] rad  [SQ_STEPS];
  sq_side_t    side [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    logic        src_vld;
    logic [34:0] src_rem;
    logic [31:0] src_root;
    logic [63:0] src_rad;
    sq_side_t    src_side;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_rad  = in_rad;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = vld[i-1];
      assign src_rem  = rem[i-1];
      assign src_root = root[i-1];
      assign src_rad  = rad[i-1];
      assign src_side = side[i-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {src_rem[32:0], src_rad[63:62]};
    assign trial  = {1'b0, src_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem[i]  <= ge ? (rem_sh - trial) : rem_sh;
      root[i] <= {src_root[30:0], ge};
      rad[i]  <= {src_rad[61:0], 2'b00};
      side[i] <= src_side;
    end
  end

  assign out_valid = vld[SQ_STEPS-1];
  assign out_root  = root[SQ_STEPS-1];
  assign out_side  = side[SQ_STEPS-1];

endmodule

### design/dsf_div.sv
// Pipelined restoring divider: three lanes share one divisor, one quotient bit per stage.
module dsf_div import dsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] in_n,
  input  lane_t       in_hi,
  input  lane_t       in_lo,
  input  dv_side_t    in_side,
  output logic        out_valid,
  output lane_t       out_q,
  output dv_side_t    out_side
);

  logic        vld  [DIV_STEPS];
  logic [31:0] dvs  [DIV_STEPS];
  lane_t       rem  [DIV_STEPS];
  lane_t       low  [DIV_STEPS];
  lane_t       quo  [DIV_STEPS];
  dv_side_t    side [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic        src_vld;
    logic [31:0] src_n;
    lane_t       src_rem;
    lane_t       src_low;
    lane_t       src_quo;
    dv_side_t    src_side;
    lane_t       nxt_rem;
    lane_t       nxt_low;
    lane_t       nxt_quo;

    if (i == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_n    = in_n;
      assign src_rem  = in_hi;
      assign src_low  = in_lo;
      assign src_quo  = '0;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = vld[i-1];
      assign src_n    = dvs[i-1];
      assign src_rem  = rem[i-1];
      assign src_low  = low[i-1];
      assign src_quo  = quo[i-1];
      assign src_side = side[i-1];
    end

    // one shift-compare-subtract per lane
    for (genvar j = 0; j < DIV_LANES; j++) begin : g_lane
      logic [32:0] t;
      logic [32:0] diff;
      logic        ge;
      assign t    = {src_rem[j], src_low[j][31]};
      assign diff = t - {1'b0, src_n};
      assign ge   = (t >= {1'b0, src_n});
      assign nxt_rem[j] = ge ? diff[31:0] : t[31:0];
      assign nxt_low[j] = {src_low[j][30:0], 1'b0};
      assign nxt_quo[j] = {src_quo[j][30:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      dvs[i]  <= src_n;
      rem[i]  <= nxt_rem;
      low[i]  <= nxt_low;
      quo[i]  <= nxt_quo;
      side[i] <= src_side;
    end
  end

  assign out_valid = vld[DIV_STEPS-1];
  assign out_q     = quo[DIV_STEPS-1];
  assign out_side  = side[DIV_STEPS-1];

endmodule

### design/damped_spring_force_2d_core.sv
// Top level: damped 2D spring force, fully pipelined, one spring per cycle.
// done marks the result of each accepted start once it has passed P1-P3, the square root, B1-B3, the divider and E1-E4.
// Throughput: one item per cycle; busy stays low, start is always taken.
// The length of the pipeline is set by the square root (32 stages) and the
// divider (32 stages) that finds the projection and both unit components.
// rst (synchronous) drops every item in flight and loads the register defaults.
module damped_spring_force_2d_core import dsf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output out_t                 result,
  output logic                 done
);

  function automatic logic signed [31:0] sat_sub(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return d[31:0];
  endfunction

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // configuration registers
  logic [31:0] stiffness, damping_gain, break_ratio, break_min_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness        <= STIFFNESS_RST;
      damping_gain     <= DAMPING_RST;
      break_ratio      <= BREAK_RATIO_RST;
      break_min_length <= BREAK_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STIFFNESS:   stiffness        <= cfg_data;
        REG_DAMPING:     damping_gain     <= cfg_data;
        REG_BREAK_RATIO: break_ratio      <= cfg_data;
        REG_BREAK_MIN:   break_min_length <= cfg_data;
      endcase
    end
  end

  assign busy = 1'b0;

  // P1: saturated differences
  logic               p1_vld;
  logic signed [31:0] p1_dx, p1_dy, p1_vx, p1_vy;
  logic        [30:0] p1_rest;

  // P2: products
  logic               p2_vld;
  logic signed [63:0] p2_sqx, p2_sqy, p2_px, p2_py;
  logic signed [31:0] p2_dx, p2_dy;
  logic        [30:0] p2_rest;
  logic signed [63:0] sqx_c, sqy_c, px_c, py_c;

  // P3: squared length and dot product
  logic        p3_vld;
  logic [63:0] p3_sum;
  sq_side_t    p3_side;
  logic [63:0] sum_c;
  logic signed [64:0] dot_w;
  logic signed [63:0] dot_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
    end else begin
      p1_vld <= start && !busy;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
    end
  end

  assign sqx_c = p1_dx * p1_dx;
  assign sqy_c = p1_dy * p1_dy;
  assign px_c  = p1_dx * p1_vx;
  assign py_c  = p1_dy * p1_vy;

  assign sum_c = p2_sqx + p2_sqy;
  assign dot_w = 65'(p2_px) + 65'(p2_py);
  // only a positive overflow is possible; clamp to the top of the range
  assign dot_c = (dot_w > 65'sh0_7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF : dot_w[63:0];

  always_ff @(posedge clk) begin
    p1_dx   <= sat_sub(item.pos_a_x, item.pos_b_x);
    p1_dy   <= sat_sub(item.pos_a_y, item.pos_b_y);
    p1_vx   <= sat_sub(item.vel_a_x, item.vel_b_x);
    p1_vy   <= sat_sub(item.vel_a_y, item.vel_b_y);
    p1_rest <= item.rest_length;

    p2_sqx  <= sqx_c;
    p2_sqy  <= sqy_c;
    p2_px   <= px_c;
    p2_py   <= py_c;
    p2_dx   <= p1_dx;
    p2_dy   <= p1_dy;
    p2_rest <= p1_rest;

    p3_sum          <= sum_c;
    p3_side.dx_neg  <= p2_dx[31];
    p3_side.dy_neg  <= p2_dy[31];
    p3_side.dx_mag  <= mag32(p2_dx);
    p3_side.dy_mag  <= mag32(p2_dy);
    p3_side.dot_neg <= dot_c[63];
    p3_side.dot_mag <= dot_c[63] ? (~dot_c + 64'd1) : dot_c;
    p3_side.rest    <= p2_rest;
  end

  // length n = floor(sqrt(dx^2 + dy^2))
  logic        sq_vld;
  logic [31:0] sq_root;
  sq_side_t    sq_side;

  dsf_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p3_vld),
    .in_rad    (p3_sum),
    .in_side   (p3_side),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // B1: stretch
  logic        b1_vld;
  logic [31:0] b1_n, b1_smag;
  logic        b1_sneg;
  sq_side_t    b1_side;
  logic signed [33:0] s_c;

  // B2: Hooke and break-limit products
  logic        b2_vld;
  logic [31:0] b2_n, b2_smag;
  logic        b2_sneg, b2_over;
  logic [63:0] b2_hprod;
  logic [62:0] b2_bprod;
  sq_side_t    b2_side;

  // B3: break decision, divider operands
  logic        b3_vld;
  logic [31:0] b3_n;
  lane_t       b3_hi, b3_lo;
  dv_side_t    b3_side;

  assign s_c = $signed({2'b00, sq_root}) - $signed({3'b000, sq_side.rest});

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld <= 1'b0;
      b2_vld <= 1'b0;
      b3_vld <= 1'b0;
    end else begin
      b1_vld <= sq_vld;
      b2_vld <= b1_vld;
      b3_vld <= b2_vld;
    end
  end

  always_ff @(posedge clk) begin
    b1_n    <= sq_root;
    b1_sneg <= s_c[33];
    b1_smag <= s_c[33] ? 32'(-s_c) : s_c[31:0];
    b1_side <= sq_side;

    b2_n     <= b1_n;
    b2_smag  <= b1_smag;
    b2_sneg  <= b1_sneg;
    b2_over  <= ({1'b0, b1_side.rest} > break_min_length);
    b2_hprod <= stiffness * b1_smag;
    b2_bprod <= break_ratio * b1_side.rest;
    b2_side  <= b1_side;

    b3_n              <= b2_n;
    // |s| * 2^16 against break_ratio * rest, both exact
    b3_side.brk       <= b2_over && ({15'h0000, b2_smag, 16'h0000} > b2_bprod);
    b3_side.nzero     <= (b2_n == 32'd0);
    b3_side.s_neg     <= b2_sneg;
    b3_side.hm        <= b2_hprod[63:16];
    b3_side.dot_neg   <= b2_side.dot_neg;
    b3_side.ovf       <= (b2_side.dot_mag[63:32] >= b2_n);
    b3_side.dx_neg    <= b2_side.dx_neg;
    b3_side.dy_neg    <= b2_side.dy_neg;
    b3_hi[LANE_DOT]   <= b2_side.dot_mag[63:32];
    b3_lo[LANE_DOT]   <= b2_side.dot_mag[31:0];
    b3_hi[LANE_UX]    <= {2'b00, b2_side.dx_mag[31:2]};
    b3_lo[LANE_UX]    <= {b2_side.dx_mag[1:0], 30'h0};
    b3_hi[LANE_UY]    <= {2'b00, b2_side.dy_mag[31:2]};
    b3_lo[LANE_UY]    <= {b2_side.dy_mag[1:0], 30'h0};
  end

  // projection and unit components, one shared divisor n
  logic     dv_vld;
  lane_t    dv_q;
  dv_side_t dv_side;

  dsf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b3_vld),
    .in_n      (b3_n),
    .in_hi     (b3_hi),
    .in_lo     (b3_lo),
    .in_side   (b3_side),
    .out_valid (dv_vld),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  // E1: damping product on the clamped projection
  logic        e1_vld;
  logic [63:0] e1_dprod;
  logic [30:0] e1_ux, e1_uy;
  dv_side_t    e1_side;
  logic [31:0] pm_c;

  // E2: total scalar force
  logic        e2_vld, e2_fneg;
  logic [48:0] e2_fmag;
  logic [30:0] e2_ux, e2_uy;
  dv_side_t    e2_side;
  logic signed [49:0] hs_c, ds_c, f_c;
  logic [47:0] dm_c;

  // E3: scaled partial products
  logic        e3_vld, e3_negx, e3_negy, e3_zero, e3_brk;
  logic [55:0] e3_ax, e3_ay;
  logic [54:0] e3_bx, e3_by;

  assign pm_c = dv_side.ovf ? 32'hFFFF_FFFF : dv_q[LANE_DOT];

  assign dm_c = e1_dprod[63:16];
  assign hs_c = e1_side.s_neg ? -$signed({2'b00, e1_side.hm}) : $signed({2'b00, e1_side.hm});
  assign ds_c = e1_side.dot_neg ? -$signed({2'b00, dm_c}) : $signed({2'b00, dm_c});
  assign f_c  = hs_c + ds_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_vld <= 1'b0;
      e2_vld <= 1'b0;
      e3_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      e1_vld <= dv_vld;
      e2_vld <= e1_vld;
      e3_vld <= e2_vld;
      done   <= e3_vld;
    end
  end

  always_ff @(posedge clk) begin
    e1_dprod <= damping_gain * pm_c;
    e1_ux    <= dv_q[LANE_UX][30:0];
    e1_uy    <= dv_q[LANE_UY][30:0];
    e1_side  <= dv_side;

    e2_fneg  <= f_c[49];
    e2_fmag  <= f_c[49] ? 49'(-f_c) : f_c[48:0];
    e2_ux    <= e1_ux;
    e2_uy    <= e1_uy;
    e2_side  <= e1_side;

    e3_ax    <= e2_ux * e2_fmag[48:24];
    e3_bx    <= e2_ux * e2_fmag[23:0];
    e3_ay    <= e2_uy * e2_fmag[48:24];
    e3_by    <= e2_uy * e2_fmag[23:0];
    e3_negx  <= e2_side.dx_neg ^ e2_fneg;
    e3_negy  <= e2_side.dy_neg ^ e2_fneg;
    e3_zero  <= e2_side.brk || e2_side.nzero;
    e3_brk   <= e2_side.brk;
  end

  // E4: recombine (u * f) >> 30 and saturate with the sign of dcomp * f
  function automatic logic [31:0] finish(logic [55:0] a, logic [54:0] b, logic neg);
    logic [55:0] lowsum;
    logic [55:0] m;
    lowsum = {26'h0, a[5:0], 24'h0} + {1'b0, b};
    m      = {6'h0, a[55:6]} + {30'h0, lowsum[55:30]};
    if (neg) begin
      return (m > 56'h8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
    end
    return (m > 56'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  always_ff @(posedge clk) begin
    result.force_x <= e3_zero ? 32'sh0 : $signed(finish(e3_ax, e3_bx, e3_negx));
    result.force_y <= e3_zero ? 32'sh0 : $signed(finish(e3_ay, e3_by, e3_negy));
    result.broken  <= e3_brk;
  end

endmodule

### design/dsf_checker.sv
// Port-level checker for the spring force core, bound to the top level.
module dsf_checker import dsf_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input in_t                  item,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]          cfg_data,
  input out_t                 result,
  input logic                 done
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");

  // every accepted item yields its result after the fixed latency
  a_item_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("item lost");

  // no result without a matching accepted item
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without item");

  // a broken spring carries no force
  a_broken_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.broken) |-> (result.force_x == 32'sh0 && result.force_y == 32'sh0))
    else $error("force on broken spring");

endmodule

bind damped_spring_force_2d_core dsf_checker u_dsf_checker (.*);
